FILE: rtl/pnd_pkg.sv
package pnd_pkg;

	localparam logic [7:0] CHAR_COMMA   = 8'h2C;
	localparam logic [1:0] PITCH_RESET  = 2'd2;
	localparam logic [5:0] CODE_UNKNOWN = 6'h3F;
	localparam logic [7:0] CMD_UNKNOWN  = 8'hFF;
	localparam logic       REG_PITCH    = 1'b0;
	localparam int         ADDR_W       = 3;

	// kept characters of the current name
	typedef struct packed {
		logic [7:0] third;
		logic [7:0] second;
		logic [7:0] first;
	} name_t;

	typedef struct packed {
		logic       known;
		logic [5:0] code;
	} lookup_t;

endpackage

FILE: rtl/phoneme_name_decoder_core.sv
// A comma word's lookup result is registered into the output slot when the word is accepted.
// Throughput: one character word per cycle; the output register frees in the same cycle
// it is taken, so the stream only stalls when the master side holds tready low.
// Reset: arst_n clears the name buffer to commas, the count to zero, the output valid,
// and sets the pitch register to 2.
module phoneme_name_decoder_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// slave side
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // [7:0] character
	// master side
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [15:0]                 m_tdata,   // [5:0] phoneme_code, [13:6] command_byte
	output logic                        m_tuser,   // [0] unknown_name
	// configuration
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pnd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [1:0]       pitch;
	pnd_pkg::name_t   name_q;
	logic [1:0]       count_q;
	pnd_pkg::lookup_t hit;

	logic             accept;
	logic             is_comma;

	logic             out_valid_q;
	logic [5:0]       out_code_q;
	logic [7:0]       out_cmd_q;
	logic             out_unknown_q;

	pnd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pitch   (pitch)
	);

	// decode the kept name straight out of the buffer registers
	pnd_lookup u_lookup (
		.name   (name_q),
		.result (hit)
	);

	// take a new word whenever the output slot is empty or drains this cycle
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_comma = (s_tdata == pnd_pkg::CHAR_COMMA);

	// name buffer: keep the first three characters, drop the rest, clear on comma
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			name_q  <= {3{pnd_pkg::CHAR_COMMA}};
			count_q <= 2'd0;
		end else if (accept) begin
			if (is_comma) begin
				name_q  <= {3{pnd_pkg::CHAR_COMMA}};
				count_q <= 2'd0;
			end else begin
				case (count_q)
					2'd0: name_q.first  <= s_tdata;
					2'd1: name_q.second <= s_tdata;
					2'd2: name_q.third  <= s_tdata;
					default: ;
				endcase
				if (count_q != 2'd3) begin
					count_q <= count_q + 2'd1;
				end
			end
		end
	end

	// output valid: set by a comma word, drop once the master side takes the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && is_comma) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload: hold until replaced by the next comma word
	always_ff @(posedge clk) begin
		if (accept && is_comma) begin
			if (hit.known) begin
				out_code_q    <= hit.code;
				out_cmd_q     <= {pitch, hit.code};
				out_unknown_q <= 1'b0;
			end else begin
				out_code_q    <= pnd_pkg::CODE_UNKNOWN;
				out_cmd_q     <= pnd_pkg::CMD_UNKNOWN;
				out_unknown_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_cmd_q, out_code_q};
	assign m_tuser  = out_unknown_q;

endmodule

FILE: rtl/pnd_lookup.sv
module pnd_lookup (
	input  pnd_pkg::name_t   name,
	output pnd_pkg::lookup_t result
);

	logic [7:0] a, b, c;
	logic       b_end, c_end;

	assign a = name.first;
	assign b = name.second;
	assign c = name.third;
	assign b_end = (b == pnd_pkg::CHAR_COMMA);
	assign c_end = (c == pnd_pkg::CHAR_COMMA);

	always_comb begin
		result.known = 1'b1;
		result.code  = pnd_pkg::CODE_UNKNOWN;
		case (a)
			"A": begin
				case (b)
					"1": result.code = 6'h05;
					"2": result.code = 6'h06;
					"Y": result.code = 6'h21;
					"E": result.code = c_end ? 6'h2E : 6'h2F;
					"H": result.code = c_end ? 6'h24 : ((c == "1") ? 6'h15 : 6'h08);
					"W": result.code = c_end ? 6'h3D : ((c == "1") ? 6'h13 : 6'h30);
					default: result.code = 6'h0E;
				endcase
			end
			"B": result.code = 6'h0E;
			"C": result.code = 6'h10;
			"D": result.code = b_end ? 6'h1E : 6'h04;
			"E": begin
				if (b_end) begin
					result.code = 6'h2C;
				end else begin
					case (b)
						"R": result.code = 6'h3A;
						"1": result.code = 6'h3C;
						"H": begin
							if (c_end) result.code = 6'h3B;
							else if (c == "1") result.code = 6'h02;
							else if (c == "2") result.code = 6'h01;
							else result.code = 6'h00;
						end
						default: result.code = 6'h1D;
					endcase
				end
			end
			"F": result.code = 6'h1D;
			"G": result.code = 6'h1C;
			"H": result.code = 6'h1B;
			"I": begin
				if (b_end) begin
					result.code = 6'h27;
				end else begin
					case (b)
						"U": result.code = 6'h36;
						"1": result.code = 6'h0B;
						"2": result.code = 6'h0A;
						default: result.code = 6'h09;
					endcase
				end
			end
			"J": result.code = 6'h1A;
			"K": result.code = 6'h19;
			"L": result.code = 6'h18;
			"M": result.code = 6'h0C;
			"N": result.code = b_end ? 6'h0D : 6'h14;
			"O": begin
				if (b_end) begin
					result.code = 6'h26;
				end else begin
					case (b)
						"1": result.code = 6'h35;
						"2": result.code = 6'h34;
						"O": result.code = c_end ? 6'h17 : 6'h16;
						// fall into the P rule
						default: result.code = (c == "0") ? 6'h03 : 6'h3E;
					endcase
				end
			end
			"P": result.code = b_end ? 6'h25 : ((c == "0") ? 6'h03 : 6'h3E);
			"R": result.code = 6'h2B;
			"S": result.code = b_end ? 6'h1F : ((b == "H") ? 6'h11 : 6'h3F);
			"T": result.code = b_end ? 6'h2A : (c_end ? 6'h39 : 6'h38);
			"U": begin
				if (b_end) result.code = 6'h28;
				else if (b == "1") result.code = 6'h37;
				else if (c_end) result.code = 6'h33;
				else if (c == "1") result.code = 6'h32;
				else if (c == "2") result.code = 6'h31;
				else result.code = 6'h23;
			end
			"V": result.code = 6'h0F;
			"W": result.code = 6'h2D;
			"Y": result.code = b_end ? 6'h29 : 6'h22;
			"Z": result.code = b_end ? 6'h12 : 6'h07;
			default: result.known = 1'b0;
		endcase
	end

endmodule

FILE: rtl/pnd_cfg.sv
module pnd_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pnd_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [1:0]                  pitch
);

	logic [1:0] pitch_q;
	logic       sel_pitch;

	assign sel_pitch = (paddr[2] == pnd_pkg::REG_PITCH);
	assign pready    = 1'b1;
	assign pitch     = pitch_q;
	assign prdata    = sel_pitch ? {30'd0, pitch_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= pnd_pkg::PITCH_RESET;
		end else if (psel && penable && pwrite && pready && sel_pitch) begin
			pitch_q <= pwdata[1:0];
		end
	end

endmodule
